>>> design/spd_pkg.sv
// shared types and constants of the sensor packet deframer
`timescale 1ns / 1ps
`default_nettype none

package spd_pkg;

   localparam int MAX_WORDS_DEF = 15;
   localparam int CNT_W         = 4;
   localparam int FLAG_W        = 6;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [7:0] HDR_S = 8'h73;
   localparam logic [7:0] HDR_N = 8'h6e;
   localparam logic [7:0] HDR_P = 8'h70;

   // packet descriptor handed from parser to output side
   typedef struct packed {
      logic [7:0]        address;
      logic [FLAG_W-1:0] flags;
      logic [CNT_W-1:0]  words;
      logic              bank;
   } desc_type;

   // payload word write into the word store
   typedef struct packed {
      logic             en;
      logic             bank;
      logic [CNT_W-1:0] index;
      logic [31:0]      data;
   } wr_type;

   // bank release from output side
   typedef struct packed {
      logic valid;
      logic bank;
   } rel_type;

endpackage

`default_nettype wire

>>> design/spd_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface spd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source(output valid, output rx_byte, input ready);
   modport sink(input valid, input rx_byte, output ready);
endinterface

interface spd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  start_address;
   logic [3:0]  word_index;
   logic [31:0] data_word;
   logic        has_data;
   logic        batch_flag;
   logic [3:0]  batch_count;
   logic        last;

   modport source(output valid, output start_address, output word_index, output data_word,
                  output has_data, output batch_flag, output batch_count, output last,
                  input ready);
   modport sink(input valid, input start_address, input word_index, input data_word,
                input has_data, input batch_flag, input batch_count, input last,
                output ready);
endinterface

`default_nettype wire

>>> design/spd_front.sv
// byte parser: header hunt, payload capture, checksum check
`timescale 1ns / 1ps
`default_nettype none

module spd_front #(
   parameter int MAX_WORDS = spd_pkg::MAX_WORDS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   spd_req_if.sink           req_chan,
   output spd_pkg::wr_type   wr_out,
   output logic              push_valid,
   output spd_pkg::desc_type push_desc,
   input  logic              queue_full,
   input  spd_pkg::rel_type  rel_in
);

   localparam int ByteW = $clog2(4 * MAX_WORDS + 1);
   localparam logic [spd_pkg::CNT_W-1:0] MaxCnt = spd_pkg::CNT_W'(MAX_WORDS);

   typedef enum logic [7:0] {
      PH_HUNT = 8'b0000_0001,
      PH_S    = 8'b0000_0010,
      PH_SN   = 8'b0000_0100,
      PH_SNP  = 8'b0000_1000,
      PH_ADDR = 8'b0001_0000,
      PH_DATA = 8'b0010_0000,
      PH_CHK1 = 8'b0100_0000,
      PH_CHK0 = 8'b1000_0000
   } phase_type;

   phase_type                   phase_ff, phase_in;
   logic [15:0]                 sum_ff, sum_in;
   logic [spd_pkg::FLAG_W-1:0]  flags_ff, flags_in;
   logic [7:0]                  addr_ff, addr_in;
   logic [spd_pkg::CNT_W-1:0]   exp_ff, exp_in;
   logic [ByteW-1:0]            bytes_ff, bytes_in;
   logic [7:0]                  chk_hi_ff, chk_hi_in;
   logic [23:0]                 shift_ff, shift_in;
   logic                        bank_ff, bank_in;
   logic [1:0]                  busy_ff, busy_in;

   logic                        accept;
   logic [7:0]                  b;
   logic [spd_pkg::CNT_W-1:0]   cnt;
   logic [15:0]                 sum_add;

   assign req_chan.ready = !((phase_ff == PH_DATA) && busy_ff[bank_ff])
                         && !((phase_ff == PH_CHK0) && queue_full);
   assign accept  = req_chan.valid && req_chan.ready;
   assign b       = req_chan.rx_byte;
   assign cnt     = b[5:2];
   assign sum_add = sum_ff + {8'h00, b};

   assign push_desc.address = addr_ff;
   assign push_desc.flags   = flags_ff;
   assign push_desc.words   = exp_ff;
   assign push_desc.bank    = bank_ff;

   always_comb begin
      phase_in   = phase_ff;
      sum_in     = sum_ff;
      flags_in   = flags_ff;
      addr_in    = addr_ff;
      exp_in     = exp_ff;
      bytes_in   = bytes_ff;
      chk_hi_in  = chk_hi_ff;
      shift_in   = shift_ff;
      bank_in    = bank_ff;
      busy_in    = busy_ff;
      push_valid = 1'b0;
      wr_out.en    = 1'b0;
      wr_out.bank  = bank_ff;
      wr_out.index = spd_pkg::CNT_W'(bytes_ff >> 2);
      wr_out.data  = {shift_ff, b};

      if (rel_in.valid) begin
         busy_in[rel_in.bank] = 1'b0;
      end

      if (accept) begin
         case (phase_ff)
            PH_HUNT: begin
               if (b == spd_pkg::HDR_S) begin
                  sum_in   = {8'h00, b};
                  phase_in = PH_S;
               end else begin
                  sum_in = 16'h0000;
               end
            end
            PH_S: begin
               if (b == spd_pkg::HDR_N) begin
                  sum_in   = sum_add;
                  phase_in = PH_SN;
               end else begin
                  sum_in   = 16'h0000;
                  phase_in = PH_HUNT;
               end
            end
            PH_SN: begin
               if (b == spd_pkg::HDR_P) begin
                  sum_in   = sum_add;
                  phase_in = PH_SNP;
               end else begin
                  sum_in   = 16'h0000;
                  phase_in = PH_HUNT;
               end
            end
            PH_SNP: begin
               sum_in   = sum_add;
               flags_in = b[7:2];
               if (!b[7]) begin
                  exp_in = '0;
               end else if (b[6]) begin
                  exp_in = (cnt > MaxCnt) ? MaxCnt : cnt;
               end else begin
                  exp_in = spd_pkg::CNT_W'(1);
               end
               phase_in = PH_ADDR;
            end
            PH_ADDR: begin
               sum_in   = sum_add;
               addr_in  = b;
               bytes_in = '0;
               phase_in = (exp_ff == '0) ? PH_CHK1 : PH_DATA;
            end
            PH_DATA: begin
               sum_in    = sum_add;
               shift_in  = {shift_ff[15:0], b};
               wr_out.en = (bytes_ff[1:0] == 2'b11);
               bytes_in  = bytes_ff + ByteW'(1);
               if (bytes_in == ByteW'({exp_ff, 2'b00})) begin
                  phase_in = PH_CHK1;
               end
            end
            PH_CHK1: begin
               chk_hi_in = b;
               phase_in  = PH_CHK0;
            end
            PH_CHK0: begin
               if ({chk_hi_ff, b} == sum_ff) begin
                  push_valid = 1'b1;
                  if (exp_ff != '0) begin
                     busy_in[bank_ff] = 1'b1;
                     bank_in          = !bank_ff;
                  end
               end
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         sum_ff   <= '0;
         flags_ff <= '0;
         addr_ff  <= '0;
         exp_ff   <= '0;
         bytes_ff <= '0;
         chk_hi_ff <= '0;
         bank_ff  <= 1'b0;
         busy_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         flags_ff <= flags_in;
         addr_ff  <= addr_in;
         exp_ff   <= exp_in;
         bytes_ff <= bytes_in;
         chk_hi_ff <= chk_hi_in;
         bank_ff  <= bank_in;
         busy_ff  <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

endmodule

`default_nettype wire

>>> design/spd_queue.sv
// two-entry descriptor queue between parser and output side
`timescale 1ns / 1ps
`default_nettype none

module spd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  spd_pkg::desc_type push_desc,
   output logic              full,
   output logic              pop_valid,
   output spd_pkg::desc_type pop_desc,
   input  logic              pop_ready
);

   localparam int PtrW = $clog2(spd_pkg::QUEUE_DEPTH);
   localparam int CntW = $clog2(spd_pkg::QUEUE_DEPTH + 1);

   spd_pkg::desc_type entry_ff [spd_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == CntW'(spd_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_desc  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(spd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(spd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

>>> design/spd_back.sv
// output side: word store and response sequencer
`timescale 1ns / 1ps
`default_nettype none

module spd_back #(
   parameter int MAX_WORDS = spd_pkg::MAX_WORDS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  spd_pkg::wr_type   wr_in,
   input  logic              pop_valid,
   input  spd_pkg::desc_type pop_desc,
   output logic              pop_ready,
   output spd_pkg::rel_type  rel_out,
   spd_rsp_if.source         rsp_chan
);

   localparam int WordAW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int MemDepth = 2 ** (WordAW + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_LOAD = 4'b0100,
      ST_SHOW = 4'b1000
   } back_state_type;

   logic [31:0]               store_mem [MemDepth];
   logic [31:0]               rd_data_ff;
   logic                      rd_en;
   logic [WordAW:0]           rd_addr;
   logic [WordAW:0]           wr_addr;

   back_state_type            state_ff, state_in;
   spd_pkg::desc_type         cur_ff, cur_in;
   logic [spd_pkg::CNT_W-1:0] widx_ff, widx_in;
   logic [31:0]               out_word_ff, out_word_in;
   logic [spd_pkg::CNT_W-1:0] out_idx_ff, out_idx_in;
   logic                      out_last_ff, out_last_in;
   logic                      is_last_word;

   assign wr_addr = {wr_in.bank, wr_in.index[WordAW-1:0]};
   assign rd_addr = {cur_ff.bank, widx_ff[WordAW-1:0]};
   assign rd_en   = (state_ff == ST_READ);
   assign is_last_word = ((widx_ff + spd_pkg::CNT_W'(1)) == cur_ff.words);

   always_ff @(posedge clock) begin
      if (wr_in.en) begin
         store_mem[wr_addr] <= wr_in.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rsp_chan.valid         = (state_ff == ST_SHOW);
   assign rsp_chan.start_address = cur_ff.address;
   assign rsp_chan.word_index    = out_idx_ff;
   assign rsp_chan.data_word     = out_word_ff;
   assign rsp_chan.has_data      = cur_ff.flags[5];
   assign rsp_chan.batch_flag    = cur_ff.flags[4];
   assign rsp_chan.batch_count   = cur_ff.flags[3:0];
   assign rsp_chan.last          = out_last_ff;

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      widx_in       = widx_ff;
      out_word_in   = out_word_ff;
      out_idx_in    = out_idx_ff;
      out_last_in   = out_last_ff;
      pop_ready     = 1'b0;
      rel_out.valid = 1'b0;
      rel_out.bank  = cur_ff.bank;

      case (state_ff)
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               cur_in  = pop_desc;
               widx_in = '0;
               if (pop_desc.words == '0) begin
                  // header-only packet
                  out_word_in = '0;
                  out_idx_in  = '0;
                  out_last_in = 1'b1;
                  state_in    = ST_SHOW;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            out_word_in = rd_data_ff;
            out_idx_in  = widx_ff;
            out_last_in = is_last_word;
            state_in    = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_chan.ready) begin
               if (out_last_ff) begin
                  rel_out.valid = (cur_ff.words != '0);
                  state_in      = ST_IDLE;
               end else begin
                  widx_in  = widx_ff + spd_pkg::CNT_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      widx_ff     <= widx_in;
      out_word_ff <= out_word_in;
      out_idx_ff  <= out_idx_in;
      out_last_ff <= out_last_in;
   end

endmodule

`default_nettype wire

>>> design/sensor_packet_deframer_core.sv
// sensor packet deframer top level
//
// req_chan carries one received byte per request; rsp_chan carries one
// decoded 32-bit word per response, or a single header-only response.
// the parser accepts one byte per cycle; it holds off only while the
// payload bank it must write is still being drained, or while the
// descriptor queue is full at the final checksum byte.
// with the output side idle, a good packet's descriptor passes through the
// descriptor queue, then each word is fetched through the registered read of
// the word store and the output register before it is presented; a
// header-only packet is presented straight from its descriptor.
// a packet with a bad checksum produces nothing.
// two payload banks and a two-entry descriptor queue let the next packet
// be received while the previous one is delivered.
// reset returns the parser to header hunting and empties the queue.
// when the receiver stalls, the response holds in its register and the
// parser keeps taking bytes until it needs a busy bank or meets a full queue.
`timescale 1ns / 1ps
`default_nettype none

module sensor_packet_deframer_core #(
   parameter int MAX_WORDS = spd_pkg::MAX_WORDS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   spd_req_if.sink    req_chan,
   spd_rsp_if.source  rsp_chan
);

   spd_pkg::wr_type   wr;
   spd_pkg::rel_type  rel;
   spd_pkg::desc_type push_desc;
   spd_pkg::desc_type pop_desc;
   logic              push_valid;
   logic              queue_full;
   logic              pop_valid;
   logic              pop_ready;

   spd_front #(
      .MAX_WORDS(MAX_WORDS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .wr_out     (wr),
      .push_valid (push_valid),
      .push_desc  (push_desc),
      .queue_full (queue_full),
      .rel_in     (rel)
   );

   spd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_desc  (push_desc),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_desc   (pop_desc),
      .pop_ready  (pop_ready)
   );

   spd_back #(
      .MAX_WORDS(MAX_WORDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .wr_in     (wr),
      .pop_valid (pop_valid),
      .pop_desc  (pop_desc),
      .pop_ready (pop_ready),
      .rel_out   (rel),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire
